>>> design/ucb1_pkg.sv
// shared constants for the ucb1 action selector
package ucb1_pkg;

    // default limit on children per node
    localparam int MAX_CHILDREN_DEF = 16;

    // field widths
    localparam int CNT_W   = 24;
    localparam int MEAN_W  = 32;
    localparam int WGT_W   = 24;
    localparam int IDX_OUT_W = 4;

    // ln2 in unsigned q0.16, truncated
    localparam logic [15:0] LN2_Q16 = 16'd45426;

    // iteration counts of the shared datapath
    localparam int LOG_STEPS  = 16;
    localparam int DIV_STEPS  = 37;
    localparam int SQRT_STEPS = 19;

    // score limits
    localparam logic signed [31:0] SCORE_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;

    // reset value of the exploration weight (1.0 in q8.16)
    localparam logic [WGT_W-1:0] WGT_RESET = 24'd65536;

endpackage

>>> design/ucb1_action_selector_core.sv
// ucb1 child selection with a shared multiplier, divider and square root sequencer
// sequence: an unvisited, ignored or low-parent-count child goes from accept straight to
//   the update step; a scored child passes accept, 16 log squarings, one ln scale, 37
//   divide steps, 19 square root steps, one bonus multiply and the update, in turn on
//   the one shared multiplier and the one-bit-per-cycle divide and root loops
// a new child is taken in only in idle, once the last one is through; the result of a
//   node is registered at the update step of its last child, and that step waits while
//   an earlier result is still not taken
// reset: asynchronous active low, clears the running best and the weight to 1.0
module ucb1_action_selector_core
#(
    parameter int MAX_CHILDREN = ucb1_pkg::MAX_CHILDREN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // exploration weight write
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata,
    // child input: total_visits[23:0], child_visits[47:24], child_mean[79:48]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        s_tlast,
    // result: best_index[3:0], best_score[35:4], zero pad[39:36]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    // result flag: no_action[0]
    output logic [0:0]  m_tuser
);
    import ucb1_pkg::*;

    localparam int POS_W = $clog2(MAX_CHILDREN + 1);
    localparam int IDX_W = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_LOG    = 7'b0000010,
        ST_LN     = 7'b0000100,
        ST_DIV    = 7'b0001000,
        ST_SQRT   = 7'b0010000,
        ST_BONUS  = 7'b0100000,
        ST_UPDATE = 7'b1000000
    } state_t;

    state_t             state_reg;
    logic [5:0]         cnt_reg;
    logic [WGT_W-1:0]   weight_reg;

    // item registers
    logic [CNT_W-1:0]   visits_reg;
    logic signed [31:0] mean_reg;
    logic               last_reg;

    // datapath registers
    logic [4:0]         k_reg;
    logic [31:0]        y_reg;
    logic [15:0]        frac_reg;
    logic [36:0]        num_reg;
    logic [23:0]        rem_reg;
    logic [37:0]        res_reg;
    logic [36:0]        bit_reg;
    logic [26:0]        bonus_reg;

    // node state
    logic signed [31:0] best_score_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               have_best_reg;
    logic               found_unv_reg;

    // output register
    logic               out_valid_reg;
    logic [IDX_OUT_W-1:0] out_idx_reg;
    logic signed [31:0] out_score_reg;
    logic               out_none_reg;

    // input fields
    logic [CNT_W-1:0]   in_total;
    logic [CNT_W-1:0]   in_visits;
    logic signed [31:0] in_mean;
    logic               in_accept;
    logic [4:0]         in_k;
    logic [31:0]        in_y;
    logic               pos_ok;

    assign in_total  = s_tdata[23:0];
    assign in_visits = s_tdata[47:24];
    assign in_mean   = s_tdata[79:48];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign pos_ok    = (pos_reg < POS_W'(MAX_CHILDREN));

    // top set bit of the parent count
    always_comb
    begin
        in_k = 5'd0;
        for (int i = 0; i < CNT_W; i++)
        begin
            if (in_total[i])
            begin
                in_k = 5'(i);
            end
        end
    end

    // normalize to q1.31
    assign in_y = {8'b0, in_total} << (5'd31 - in_k);

    // shared multiplier operand select
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    always_comb
    begin
        unique case (state_reg)
            ST_LOG:
            begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            ST_LN:
            begin
                mul_a = {11'b0, k_reg, frac_reg};
                mul_b = {16'b0, LN2_Q16};
            end
            ST_BONUS:
            begin
                mul_a = {8'b0, weight_reg};
                mul_b = {13'b0, res_reg[18:0]};
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // divide step
    logic [24:0] div_rem;
    logic        div_q;
    assign div_rem = {rem_reg, num_reg[36]};
    assign div_q   = (div_rem >= {1'b0, visits_reg});

    // square root step
    logic [37:0] sq_trial;
    logic        sq_take;
    assign sq_trial = res_reg + {1'b0, bit_reg};
    assign sq_take  = ({1'b0, num_reg} >= sq_trial);

    // score and running best update
    logic signed [32:0] sum_wide;
    logic signed [31:0] score_sat;
    logic               take_unv;
    logic               take_vis;
    logic               have_next;
    logic [IDX_W-1:0]   idx_next;
    logic signed [31:0] score_next;
    logic [IDX_W+3:0]   idx_wide;
    logic               out_stall;
    logic               out_load;

    assign sum_wide  = {mean_reg[31], mean_reg} + $signed({6'b0, bonus_reg});
    assign score_sat = (!sum_wide[32] && sum_wide[31]) ? SCORE_MAX : sum_wide[31:0];
    assign take_unv  = pos_ok && (visits_reg == '0) && !found_unv_reg;
    assign take_vis  = pos_ok && (visits_reg != '0) && !found_unv_reg &&
                       (!have_best_reg || (score_sat > best_score_reg));
    assign have_next = have_best_reg || take_unv || take_vis;
    assign idx_next  = (take_unv || take_vis) ? IDX_W'(pos_reg) : best_idx_reg;
    assign score_next = take_unv ? SCORE_MAX : (take_vis ? score_sat : best_score_reg);
    assign idx_wide  = {4'b0, idx_next};
    assign out_stall = last_reg && out_valid_reg && !m_tready;
    assign out_load  = (state_reg == ST_UPDATE) && last_reg && !out_stall;

    // weight register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= WGT_RESET;
        end
        else if (cfg_we)
        begin
            weight_reg <= cfg_wdata;
        end
    end

    // sequencer and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            best_score_reg <= SCORE_MIN;
            best_idx_reg   <= '0;
            pos_reg        <= '0;
            have_best_reg  <= 1'b0;
            found_unv_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        visits_reg <= in_visits;
                        mean_reg   <= in_mean;
                        last_reg   <= s_tlast;
                        k_reg      <= in_k;
                        y_reg      <= in_y;
                        frac_reg   <= '0;
                        bonus_reg  <= '0;
                        cnt_reg    <= 6'(LOG_STEPS - 1);
                        if (pos_ok && (in_visits != '0) && !found_unv_reg && (in_total > 24'd1))
                        begin
                            state_reg <= ST_LOG;
                        end
                        else
                        begin
                            state_reg <= ST_UPDATE;
                        end
                    end
                end
                ST_LOG:
                begin
                    // square and pull one fraction bit
                    if (mul_p[63])
                    begin
                        y_reg    <= mul_p[63:32];
                        frac_reg <= {frac_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        y_reg    <= mul_p[62:31];
                        frac_reg <= {frac_reg[14:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= ST_LN;
                    end
                end
                ST_LN:
                begin
                    state_reg <= ST_DIV;
                    cnt_reg   <= 6'(DIV_STEPS - 1);
                    rem_reg   <= '0;
                    num_reg   <= {mul_p[36:16], 16'b0};
                end
                ST_DIV:
                begin
                    // restoring divide, one quotient bit
                    rem_reg <= div_q ? 24'(div_rem - {1'b0, visits_reg}) : div_rem[23:0];
                    num_reg <= {num_reg[35:0], div_q};
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= ST_SQRT;
                        cnt_reg   <= 6'(SQRT_STEPS - 1);
                        res_reg   <= '0;
                        bit_reg   <= 37'h1 << 36;
                    end
                end
                ST_SQRT:
                begin
                    // one root bit
                    if (sq_take)
                    begin
                        num_reg <= 37'({1'b0, num_reg} - sq_trial);
                        res_reg <= (res_reg >> 1) + {1'b0, bit_reg};
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= ST_BONUS;
                    end
                end
                ST_BONUS:
                begin
                    bonus_reg <= mul_p[42:16];
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    if (!out_stall)
                    begin
                        state_reg <= ST_IDLE;
                        if (last_reg)
                        begin
                            out_valid_reg  <= 1'b1;
                            out_none_reg   <= !have_next;
                            out_idx_reg    <= have_next ? idx_wide[3:0] : '0;
                            out_score_reg  <= have_next ? score_next : '0;
                            best_score_reg <= SCORE_MIN;
                            best_idx_reg   <= '0;
                            pos_reg        <= '0;
                            have_best_reg  <= 1'b0;
                            found_unv_reg  <= 1'b0;
                        end
                        else
                        begin
                            best_score_reg <= score_next;
                            best_idx_reg   <= idx_next;
                            have_best_reg  <= have_next;
                            found_unv_reg  <= found_unv_reg || take_unv;
                            if (pos_ok)
                            begin
                                pos_reg <= pos_reg + POS_W'(1);
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result ports
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_score_reg, out_idx_reg};
    assign m_tuser  = out_none_reg;

`ifndef SYNTHESIS
    // position counter never passes the child limit
    a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_CHILDREN))
        else $error("child position past limit");

    // an unvisited child always leaves a best in place
    a_unv_best: assert property (@(posedge clk) disable iff (!rst_n)
        found_unv_reg |-> (have_best_reg && best_score_reg == SCORE_MAX))
        else $error("unvisited child without max best");

    // no-action result carries zero index and score
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 40'd0))
        else $error("no-action result with data");

    // only the update step raises a result
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_UPDATE))
        else $error("result outside update");
`endif

endmodule
